### hw/rtl/cd_sector_field_extractor_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the CD sector field extractor
// Concurrent checks written in two forms, sampled on the rising clock and
// disabled while reset is held.
// ---------------------------------------------------------------------------
`ifndef CD_SECTOR_FIELD_EXTRACTOR_TOP_ASSERT_SVH
`define CD_SECTOR_FIELD_EXTRACTOR_TOP_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define CDSFE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cdsfe check failed");

// Consequent holds in the cycle after the antecedent.
`define CDSFE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cdsfe check failed");

`endif

### hw/rtl/cdsfe_pkg.sv
// ---------------------------------------------------------------------------
// cdsfe_pkg
// Constants, codes, legality tables and sector classification for the
// CD sector field extractor.
// ---------------------------------------------------------------------------
package cdsfe_pkg;

    localparam int SECTOR_LEN     = 2352;
    localparam int POS_W          = 12;
    localparam int DELAY_LEN      = 24;
    localparam int DELAY_LAG      = DELAY_LEN - 1;
    localparam int IDX_W          = $clog2(DELAY_LEN);
    localparam int MODE_OFFSET    = 15;
    localparam int SUBHEAD_OFFSET = 18;
    localparam int FORM2_BIT      = 5;     // 0x20 of the subheader byte

    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int LEN_W     = 12;
    localparam int IN_DATA_W = 8;
    localparam int OUT_DATA_W = 24;        // byte, status, length, pad
    localparam int RT_W      = 3;
    localparam int MASK_W    = 5;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_READ_TYPE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_MASK = 1'b1;

    // Sector kinds
    localparam logic [1:0] KIND_UNKNOWN = 2'd0;
    localparam logic [1:0] KIND_MODE1   = 2'd1;
    localparam logic [1:0] KIND_FORM1   = 2'd2;
    localparam logic [1:0] KIND_FORM2   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_UNKNOWN  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BADMODE  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BADFIELD = 2'd3;

    // Read types
    localparam logic [RT_W-1:0] RT_ANY      = 3'd0;
    localparam logic [RT_W-1:0] RT_CDDA     = 3'd1;
    localparam logic [RT_W-1:0] RT_MODE1    = 3'd2;
    localparam logic [RT_W-1:0] RT_FORM1    = 3'd3;
    localparam logic [RT_W-1:0] RT_FORM2    = 3'd4;
    localparam logic [RT_W-1:0] RT_FORMLESS = 3'd5;

    localparam logic [RT_W-1:0]   READ_TYPE_RST  = RT_ANY;
    localparam logic [MASK_W-1:0] FIELD_MASK_RST = 5'd2;

    // Field mask legality, bit i for mask value i
    localparam logic [31:0] LEGAL_PLAIN = 32'hD0D1_DDDF;
    localparam logic [31:0] LEGAL_XA    = 32'hD011_DD1F;

    // Field boundaries: sync, header, subheader, data, ecc, end
    localparam int NFIELDS = 5;
    typedef logic [NFIELDS:0][POS_W-1:0] layout_t;
    localparam layout_t LAYOUT_MODE1 =
        {12'd2352, 12'd2064, 12'd16, 12'd16, 12'd12, 12'd0};
    localparam layout_t LAYOUT_FORM1 =
        {12'd2352, 12'd2072, 12'd24, 12'd16, 12'd12, 12'd0};
    localparam layout_t LAYOUT_FORM2 =
        {12'd2352, 12'd2352, 12'd24, 12'd16, 12'd12, 12'd0};

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    range_lo;
        logic [POS_W-1:0]    range_hi;
        logic [LEN_W-1:0]    length;
    } class_t;

    function automatic class_t classify(
        input logic [BYTE_W-1:0] mode_byte,
        input logic [BYTE_W-1:0] sub_byte,
        input logic [RT_W-1:0]   rtype,
        input logic [MASK_W-1:0] mask
    );
        class_t              c;
        logic [1:0]          kind;
        layout_t             lay;
        logic                rt_match;
        logic                rt_illegal;
        logic                legal;
        logic                have;
        logic                gap;
        logic [POS_W-1:0]    s;
        logic [POS_W-1:0]    e;
        c = '0;
        if (mode_byte == 8'd1) begin
            kind = KIND_MODE1;
        end else if (mode_byte == 8'd2) begin
            kind = sub_byte[FORM2_BIT] ? KIND_FORM2 : KIND_FORM1;
        end else begin
            kind = KIND_UNKNOWN;
        end

        unique case (kind)
            KIND_MODE1: lay = LAYOUT_MODE1;
            KIND_FORM1: lay = LAYOUT_FORM1;
            KIND_FORM2: lay = LAYOUT_FORM2;
            default:    lay = '0;
        endcase

        rt_illegal = 1'b0;
        unique case (rtype) inside
            RT_ANY:           rt_match = 1'b1;
            RT_MODE1, RT_FORM1:
                rt_match = (kind == KIND_MODE1) || (kind == KIND_FORM1);
            RT_FORM2:         rt_match = (kind == KIND_FORM2);
            RT_CDDA, RT_FORMLESS: rt_match = 1'b0;
            default: begin
                rt_match   = 1'b0;
                rt_illegal = 1'b1;
            end
        endcase

        legal = (kind == KIND_MODE1) ? LEGAL_PLAIN[mask] : LEGAL_XA[mask];

        // walk the selected fields, sync first; a hole breaks contiguity
        have = 1'b0;
        gap  = 1'b0;
        s    = '0;
        e    = '0;
        for (int i = 0; i < NFIELDS; i++) begin
            if (mask[NFIELDS-1-i]) begin
                if (!have) begin
                    s    = lay[i];
                    have = 1'b1;
                end else if (e != lay[i]) begin
                    gap = 1'b1;
                end
                e = lay[i+1];
            end
        end

        if (kind == KIND_UNKNOWN) begin
            c.status = STAT_UNKNOWN;
        end else if (rt_illegal) begin
            c.status = STAT_BADFIELD;
        end else if (!rt_match) begin
            c.status = STAT_BADMODE;
        end else if (!legal || gap) begin
            c.status = STAT_BADFIELD;
        end else begin
            c.status = STAT_OK;
            if (have) begin
                c.range_lo = s;
                c.range_hi = e;
                c.length   = LEN_W'(e - s);
            end
        end
        return c;
    endfunction

endpackage

### hw/rtl/cd_sector_field_extractor_top.sv
// ---------------------------------------------------------------------------
// CD sector field extractor
// Classifies raw CD sectors and forwards the requested byte range plus a
// closing status per sector.
// ---------------------------------------------------------------------------
// Raw sector bytes enter one per cycle while the input is not stalled or
// paused. Each byte is written into a 24-entry delay-line memory (one write
// and one registered read port); the byte 23 positions back is read in the
// same cycle and passes through rd_data_reg and then m_tdata_reg if it lies in
// the selected range. The sector is classified when byte 18 arrives, using
// read_type and field_mask as they stand then. After byte 2351 the input
// pauses while the flush state drains the remaining buffered bytes through
// the single read port, then the close state issues the closing status request.
// Output back-pressure stalls the input directly through the read pipeline.
module cd_sector_field_extractor_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // sector_byte[7:0]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [cdsfe_pkg::IN_DATA_W-1:0]    s_tdata,
    // out_byte[7:0], status[9:8], extracted_length[21:10], zero pad [23:22]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cdsfe_pkg::OUT_DATA_W-1:0]   m_tdata,
    // has_byte[0]
    output logic                               m_tuser,
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cdsfe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cdsfe_pkg::MASK_W-1:0]       cfg_data
);
    import cdsfe_pkg::*;

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_FLUSH = 2'd1;
    localparam logic [1:0] ST_CLOSE = 2'd2;

    localparam logic [POS_W-1:0] POS_LAST     = POS_W'(SECTOR_LEN - 1);
    localparam logic [POS_W-1:0] POS_MODE     = POS_W'(MODE_OFFSET);
    localparam logic [POS_W-1:0] POS_SUBHEAD  = POS_W'(SUBHEAD_OFFSET);
    localparam logic [POS_W-1:0] POS_LAG      = POS_W'(DELAY_LAG);
    localparam logic [POS_W-1:0] FLUSH_FIRST  = POS_W'(SECTOR_LEN - DELAY_LAG);
    localparam logic [IDX_W-1:0] FLUSH_IDX0   = IDX_W'((SECTOR_LEN - DELAY_LAG) % DELAY_LEN);
    localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(DELAY_LEN - 1);

    // delay-line memory
    logic [BYTE_W-1:0] dl_mem [DELAY_LEN];
    logic [BYTE_W-1:0] rd_data_reg;

    logic [1:0]          state_reg, state_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [IDX_W-1:0]    wr_idx_reg, wr_idx_next;
    logic [POS_W-1:0]    flush_q_reg, flush_q_next;
    logic [IDX_W-1:0]    flush_idx_reg, flush_idx_next;
    logic [BYTE_W-1:0]   mode_byte_reg;
    logic [RT_W-1:0]     read_type_reg;
    logic [MASK_W-1:0]   field_mask_reg;
    class_t              sect_reg, sect_next;

    logic                pipe_valid_reg, pipe_valid_next;
    logic                pipe_close_reg, pipe_close_next;
    logic [STATUS_W-1:0] pipe_status_reg;
    logic [LEN_W-1:0]    pipe_len_reg;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                m_tuser_reg;
    logic                m_tlast_reg;

    logic                out_free;
    logic                advance;
    logic                accept;
    logic [IDX_W-1:0]    rd_idx;
    logic [IDX_W-1:0]    wr_idx_inc;
    logic [POS_W-1:0]    q;
    logic                q_live;
    logic                emit;
    class_t              class_now;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign advance   = !pipe_valid_reg || out_free;
    assign s_tready  = advance && (state_reg == ST_RUN);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign wr_idx_inc = (wr_idx_reg == IDX_LAST) ? '0 : wr_idx_reg + 1'b1;
    assign rd_idx     = (state_reg == ST_RUN) ? wr_idx_inc : flush_idx_reg;

    // offset whose byte leaves on this request
    assign q      = (state_reg == ST_RUN) ? pos_reg - POS_LAG : flush_q_reg;
    assign q_live = (state_reg == ST_FLUSH) || (pos_reg >= POS_LAG);
    assign emit   = q_live && (sect_reg.status == STAT_OK)
                    && (q >= sect_reg.range_lo) && (q < sect_reg.range_hi);

    assign class_now = classify(mode_byte_reg, s_tdata, read_type_reg, field_mask_reg);

    always_ff @(posedge aclk) begin
        if (accept) begin
            dl_mem[wr_idx_reg] <= s_tdata;
        end
        if (advance) begin
            rd_data_reg <= dl_mem[rd_idx];
        end
    end

    always_comb begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        wr_idx_next     = wr_idx_reg;
        flush_q_next    = flush_q_reg;
        flush_idx_next  = flush_idx_reg;
        sect_next       = sect_reg;
        pipe_valid_next = pipe_valid_reg;
        pipe_close_next = pipe_close_reg;

        if (advance) begin
            pipe_valid_next = 1'b0;
            pipe_close_next = 1'b0;
            unique case (state_reg)
                ST_RUN: begin
                    if (accept) begin
                        pipe_valid_next = emit;
                        wr_idx_next     = wr_idx_inc;
                        if (pos_reg == POS_SUBHEAD) begin
                            sect_next = class_now;
                        end
                        if (pos_reg == POS_LAST) begin
                            pos_next       = '0;
                            flush_q_next   = FLUSH_FIRST;
                            flush_idx_next = FLUSH_IDX0;
                            state_next     = ST_FLUSH;
                        end else begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                end
                ST_FLUSH: begin
                    pipe_valid_next = emit;
                    flush_q_next    = flush_q_reg + 1'b1;
                    flush_idx_next  = (flush_idx_reg == IDX_LAST) ? '0 : flush_idx_reg + 1'b1;
                    if (flush_q_reg == POS_LAST) begin
                        state_next = ST_CLOSE;
                    end
                end
                ST_CLOSE: begin
                    pipe_valid_next = 1'b1;
                    pipe_close_next = 1'b1;
                    state_next      = ST_RUN;
                end
                default: begin
                    state_next = ST_RUN;
                end
            endcase
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_free) begin
            m_tvalid_next = pipe_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_RUN;
            pos_reg        <= '0;
            wr_idx_reg     <= '0;
            flush_q_reg    <= '0;
            flush_idx_reg  <= '0;
            sect_reg       <= '0;
            read_type_reg  <= READ_TYPE_RST;
            field_mask_reg <= FIELD_MASK_RST;
            pipe_valid_reg <= 1'b0;
            pipe_close_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            wr_idx_reg     <= wr_idx_next;
            flush_q_reg    <= flush_q_next;
            flush_idx_reg  <= flush_idx_next;
            sect_reg       <= sect_next;
            pipe_valid_reg <= pipe_valid_next;
            pipe_close_reg <= pipe_close_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_READ_TYPE:  read_type_reg  <= cfg_data[RT_W-1:0];
                    CFG_FIELD_MASK: field_mask_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept && (pos_reg == POS_MODE)) begin
            mode_byte_reg <= s_tdata;
        end
        if (advance) begin
            pipe_status_reg <= sect_reg.status;
            pipe_len_reg    <= (sect_reg.status == STAT_OK) ? sect_reg.length : '0;
        end
        if (out_free && pipe_valid_reg) begin
            if (pipe_close_reg) begin
                m_tdata_reg <= {2'b00, pipe_len_reg, pipe_status_reg, {BYTE_W{1'b0}}};
            end else begin
                m_tdata_reg <= {2'b00, {LEN_W{1'b0}}, {STATUS_W{1'b0}}, rd_data_reg};
            end
            m_tuser_reg <= !pipe_close_reg;
            m_tlast_reg <= pipe_close_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

`include "cd_sector_field_extractor_top_assert.svh"

    `CDSFE_ASSERT_NOW(a_no_input_in_drain, aclk, aresetn,
        state_reg != ST_RUN, !s_tready)
    `CDSFE_ASSERT_NEXT(a_drain_after_last, aclk, aresetn,
        accept && (pos_reg == POS_LAST), state_reg == ST_FLUSH)
    `CDSFE_ASSERT_NOW(a_byte_has_no_status, aclk, aresetn,
        m_tvalid && m_tuser, (m_tdata[OUT_DATA_W-1:BYTE_W] == '0) && !m_tlast)
    `CDSFE_ASSERT_NOW(a_index_in_range, aclk, aresetn,
        1'b1, (wr_idx_reg <= IDX_LAST) && (flush_idx_reg <= IDX_LAST))

endmodule
